// ===== rtl/irt_pkg.sv =====
// Shared types and codes for the interval reservation table.
package irt_pkg;

  localparam logic REQ_RESERVE = 1'b0;
  localparam logic REQ_LOOKUP  = 1'b1;

  localparam logic [2:0] ST_RESERVED = 3'd0;
  localparam logic [2:0] ST_CONFLICT = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  row_index;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [15:0] owner_tag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_owner;
  } rsp_t;

  typedef struct packed {
    logic [15:0] slot_start;
    logic [15:0] slot_end;
    logic [15:0] slot_owner;
  } slot_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_SCAN,
    S_RESULT
  } state_t;

endpackage

// ===== rtl/irt_fill_mem.sv =====
// Per-row fill count memory with a clearing sweep after reset.
module irt_fill_mem #(
  parameter int NUM_ROWS = 64,
  parameter int ROW_W    = 6,
  parameter int FILL_W   = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ROW_W-1:0]  rd_addr,
  output logic [FILL_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ROW_W-1:0]  wr_addr,
  input  logic [FILL_W-1:0] wr_data,
  output logic              busy
);

  logic [FILL_W-1:0] mem [NUM_ROWS];
  logic [ROW_W-1:0]  clr_idx;

  // The sweep owns the write port until every row holds zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      if (clr_idx == ROW_W'(NUM_ROWS - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !rst) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/irt_slot_mem.sv =====
// Interval slot memory: start, end and owner of every stored reservation.
module irt_slot_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output irt_pkg::slot_t     rd_data,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  irt_pkg::slot_t     wr_data
);
  import irt_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/irt_match.sv =====
// Shared compare unit: overlap test for reserves, cover test for lookups.
module irt_match (
  input  logic           req_type,
  input  logic [15:0]    start_pos,
  input  logic [15:0]    end_pos,
  input  irt_pkg::slot_t slot,
  output logic           hit
);
  import irt_pkg::*;

  logic start_le_end;
  logic tail_ge_start;

  // A lookup uses the queried position for both ends of the test interval.
  always_comb begin
    start_le_end  = start_pos <= slot.slot_end;
    tail_ge_start = (req_type == REQ_LOOKUP) ? (start_pos >= slot.slot_start)
                                             : (end_pos >= slot.slot_start);
    hit = start_le_end && tail_ge_start;
  end

endmodule

// ===== rtl/interval_reservation_table_core.sv =====
// Interval reservation table: each row keeps a list of inclusive intervals with owners.
//
// A request transaction on req_data (req_valid / req_stall) either reserves
// [start_pos, end_pos] for owner_tag in a row, or looks up the owner of the
// position start_pos. Each request gives exactly one response transaction on
// rsp_data (rsp_valid / rsp_stall) with a status code and the found owner.
// A reserve fails on the first overlapping stored interval, otherwise it
// appends the interval, or reports the row full when every slot is taken.
// One request is in work at a time. A request scans the stored intervals of
// its row in order, with one slot memory read and one compare per cycle
// through the shared compare unit, and answers on the first hit or after
// the last stored interval; a row out of range is answered without a scan.
// req_stall is high until the response has been placed in the output
// register, so a new request may be accepted while that response waits on
// rsp_stall. A response is loaded only when the output register is empty or
// being taken that cycle. After reset the fill counts are swept to zero, one
// row per cycle, with req_stall high. Slot contents are not cleared.
module interval_reservation_table_core #(
  parameter int NUM_ROWS      = 64,
  parameter int SLOTS_PER_ROW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  irt_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output irt_pkg::rsp_t rsp_data
);
  import irt_pkg::*;

  localparam int DEPTH  = NUM_ROWS * SLOTS_PER_ROW;
  localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(SLOTS_PER_ROW + 1);

  state_t            state, state_next;
  req_t              req_q;
  logic              row_ok, row_ok_next;
  logic [ADDR_W-1:0] base, base_next;
  logic [FILL_W-1:0] rd_idx, rd_idx_next;
  logic              cmp_valid, cmp_valid_next;
  rsp_t              res, res_next;
  logic              accept, load_rsp;

  logic              fill_busy;
  logic [FILL_W-1:0] fill;
  logic              fill_wr_en;
  logic [ROW_W-1:0]  row_sel, row_q;

  logic              slot_rd_en, slot_wr_en;
  logic [ADDR_W-1:0] slot_addr;
  slot_t             slot_rd, slot_wr;
  logic              hit;

  assign row_sel = ROW_W'(req_data.row_index);
  assign row_q   = ROW_W'(req_q.row_index);
  assign slot_addr = base + ADDR_W'(rd_idx);

  always_comb begin
    slot_wr.slot_start = req_q.start_pos;
    slot_wr.slot_end   = req_q.end_pos;
    slot_wr.slot_owner = req_q.owner_tag;
  end

  irt_fill_mem #(
    .NUM_ROWS (NUM_ROWS),
    .ROW_W    (ROW_W),
    .FILL_W   (FILL_W)
  ) u_fill (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (row_sel),
    .rd_data (fill),
    .wr_en   (fill_wr_en),
    .wr_addr (row_q),
    .wr_data (FILL_W'(fill + 1'b1)),
    .busy    (fill_busy)
  );

  irt_slot_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_slots (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_addr),
    .rd_data (slot_rd),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_addr),
    .wr_data (slot_wr)
  );

  irt_match u_match (
    .req_type  (req_q.req_type),
    .start_pos (req_q.start_pos),
    .end_pos   (req_q.end_pos),
    .slot      (slot_rd),
    .hit       (hit)
  );

  assign req_stall = (state != S_IDLE) || fill_busy;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_data;
    end
    row_ok <= row_ok_next;
    base   <= base_next;
    rd_idx <= rd_idx_next;
    res    <= res_next;
  end

  always_comb begin
    state_next     = state;
    row_ok_next    = row_ok;
    base_next      = base;
    rd_idx_next    = rd_idx;
    cmp_valid_next = 1'b0;
    res_next       = res;
    slot_rd_en     = 1'b0;
    slot_wr_en     = 1'b0;
    fill_wr_en     = 1'b0;
    load_rsp       = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          row_ok_next = 32'(req_data.row_index) < NUM_ROWS;
          state_next  = S_FILL;
        end
      end
      S_FILL: begin
        base_next   = ADDR_W'(row_q * SLOTS_PER_ROW);
        rd_idx_next = '0;
        if (!row_ok) begin
          res_next.status      = (req_q.req_type == REQ_LOOKUP) ? ST_NONE : ST_FULL;
          res_next.found_owner = '0;
          state_next           = S_RESULT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // Reads run one slot ahead of the compare on the returned entry.
        if (cmp_valid && hit) begin
          if (req_q.req_type == REQ_LOOKUP) begin
            res_next.status      = ST_FOUND;
            res_next.found_owner = slot_rd.slot_owner;
          end else begin
            res_next.status      = ST_CONFLICT;
            res_next.found_owner = '0;
          end
          state_next = S_RESULT;
        end else if (rd_idx < fill) begin
          slot_rd_en     = 1'b1;
          rd_idx_next    = rd_idx + 1'b1;
          cmp_valid_next = 1'b1;
        end else begin
          res_next.found_owner = '0;
          if (req_q.req_type == REQ_LOOKUP) begin
            res_next.status = ST_NONE;
          end else if (fill == FILL_W'(SLOTS_PER_ROW)) begin
            res_next.status = ST_FULL;
          end else begin
            // rd_idx equals the fill count here, so the slot address is the append slot.
            res_next.status = ST_RESERVED;
            slot_wr_en      = 1'b1;
            fill_wr_en      = 1'b1;
          end
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_data <= res;
    end
  end

endmodule

// ===== rtl/irt_checker.sv =====
// Port-level checker for the interval reservation table, bound to the top level.
module irt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input irt_pkg::req_t req_data,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input irt_pkg::rsp_t rsp_data
);
  import irt_pkg::*;

  // Reset starts the clearing sweep with nothing in the output register.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> req_stall && !rsp_valid)
    else $error("block not quiet after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while another is in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.status == ST_RESERVED || rsp_data.status == ST_CONFLICT ||
                  rsp_data.status == ST_FULL || rsp_data.status == ST_FOUND ||
                  rsp_data.status == ST_NONE)
    else $error("illegal response status");

  a_owner_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_FOUND |-> rsp_data.found_owner == 16'd0)
    else $error("owner reported without a match");

endmodule

bind interval_reservation_table_core irt_checker u_irt_checker (.*);
